[sv/hevm_pkg.sv]
// Shared types, request codes and envelope tables of the haptic envelope voice mixer.
package hevm_pkg;

    // Default sizing, handed to the top-level parameters.
    localparam int VOICES_PER_PAD_DEF = 4;
    localparam int PAD_COUNT_DEF      = 2;

    // Fixed field widths and limits.
    localparam int POS_W         = 6;
    localparam int PAT_W         = 3;
    localparam int GAIN_W        = 8;
    localparam int FRAMES_W      = 4;
    localparam int INT_W         = 8;
    localparam int NUM_PATTERNS  = 6;
    localparam logic [INT_W-1:0] INTENSITY_MAX = 8'd254;

    // Request codes.
    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_START  = 2'd1;
    localparam logic [1:0] REQ_STOP   = 2'd2;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // Envelope codes.
    localparam logic [PAT_W-1:0] PAT_SHORT  = 3'd0;
    localparam logic [PAT_W-1:0] PAT_MEDIUM = 3'd1;
    localparam logic [PAT_W-1:0] PAT_LONG   = 3'd2;
    localparam logic [PAT_W-1:0] PAT_STROBE = 3'd3;
    localparam logic [PAT_W-1:0] PAT_BLOWER = 3'd4;
    localparam logic [PAT_W-1:0] PAT_CHOP   = 3'd5;

    // One word of the voice memory.
    typedef struct packed {
        logic [PAT_W-1:0]  pattern;
        logic [POS_W-1:0]  position;
        logic [GAIN_W-1:0] gain;
    } voice_entry_t;

    // Outcome of advancing one voice by one tick.
    typedef struct packed {
        logic              keep;
        logic              have;
        logic [POS_W-1:0]  position;
        logic [INT_W-1:0]  amount;
    } voice_step_t;

    // Number of entries in each envelope.
    function automatic logic [POS_W-1:0] env_len(input logic [PAT_W-1:0] pat);
        logic [POS_W-1:0] len;
        unique case (pat)
            PAT_SHORT:  len = 6'd8;
            PAT_MEDIUM: len = 6'd16;
            PAT_LONG:   len = 6'd27;
            PAT_STROBE: len = 6'd52;
            PAT_BLOWER: len = 6'd6;
            PAT_CHOP:   len = 6'd6;
            default:    len = 6'd0;
        endcase
        return len;
    endfunction

    // Envelope entry at a given index; indexes past the end read as zero.
    function automatic logic [INT_W-1:0] env_entry(input logic [PAT_W-1:0] pat,
                                                   input logic [POS_W-1:0] idx);
        logic [INT_W-1:0] val;
        val = 8'd0;
        unique case (pat)
            PAT_SHORT:
            begin
                if (idx == 6'd0 || idx == 6'd7)
                    val = 8'd64;
                else if (idx == 6'd1 || idx == 6'd6)
                    val = 8'd128;
                else if (idx < 6'd8)
                    val = 8'd255;
            end
            PAT_MEDIUM:
            begin
                if (idx == 6'd0 || idx == 6'd14)
                    val = 8'd64;
                else if (idx == 6'd1 || idx == 6'd15)
                    val = 8'd128;
                else if (idx < 6'd16)
                    val = 8'd255;
            end
            PAT_LONG:
            begin
                if (idx == 6'd0 || idx == 6'd26)
                    val = 8'd64;
                else if (idx == 6'd1 || idx == 6'd25)
                    val = 8'd128;
                else if (idx < 6'd27)
                    val = 8'd255;
            end
            PAT_STROBE:
            begin
                // Runs of four: low, mid, high, mid, repeating every sixteen.
                if (idx < 6'd52)
                begin
                    unique case (idx[3:2])
                        2'd0:    val = 8'd64;
                        2'd2:    val = 8'd255;
                        default: val = 8'd128;
                    endcase
                end
            end
            PAT_BLOWER:
            begin
                unique case (idx)
                    6'd0:    val = 8'd20;
                    6'd1:    val = 8'd40;
                    6'd2:    val = 8'd15;
                    6'd3:    val = 8'd50;
                    6'd4:    val = 8'd30;
                    6'd5:    val = 8'd40;
                    default: val = 8'd0;
                endcase
            end
            PAT_CHOP:
            begin
                if (idx < 6'd3)
                    val = 8'd255;
                else if (idx < 6'd6)
                    val = 8'd200;
            end
            default: val = 8'd0;
        endcase
        return val;
    endfunction

endpackage

[sv/haptic_envelope_voice_mixer_top.sv]
// Top level of the haptic envelope voice mixer: voice memory, tick walk and pad sums.
//
// A word is accepted when start is high and busy is low. Start and stop-all
// words, and the unused request code, finish at that edge and raise done in
// the next cycle with the pad intensities on the result ports. A tick word
// walks the voice memory one voice per cycle through a three-stage read,
// envelope and multiply-accumulate pipe and keeps busy high until the last
// voice has left the multiply-accumulate stage; busy then falls and done rises
// at the same edge. The single voice memory and the shared 8x8 multiplier
// serve every voice in turn. done is high for exactly one cycle per accepted
// word and the receiver cannot stall it; the intensity ports hold their values
// until the next word changes them.
module haptic_envelope_voice_mixer_top
#(
    parameter int VOICES_PER_PAD = hevm_pkg::VOICES_PER_PAD_DEF,
    parameter int PAD_COUNT      = hevm_pkg::PAD_COUNT_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic       pad_sel,
    input  logic [2:0] pattern,
    input  logic [7:0] gain,
    input  logic [3:0] frames,
    input  logic [1:0] victim_slot,
    output logic       done,
    output logic [7:0] intensity_pad0,
    output logic [7:0] intensity_pad1
);

    localparam int TOTAL   = PAD_COUNT * VOICES_PER_PAD;
    localparam int ADDR_W  = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int VOICE_W = (VOICES_PER_PAD > 1) ? $clog2(VOICES_PER_PAD) : 1;
    localparam int PAD_W   = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_TICK = 1'b1;

    logic                       state_reg;
    logic                       done_reg;
    logic                       accept;
    logic [TOTAL-1:0]           active_reg;
    logic [7:0]                 pad_int_reg [PAD_COUNT];
    logic [hevm_pkg::FRAMES_W-1:0] frames_reg;

    // Voice memory: pattern, position and gain of each voice.
    hevm_pkg::voice_entry_t     voice_mem [TOTAL];
    hevm_pkg::voice_entry_t     rdata_reg;

    // Issue stage of the tick walk.
    logic                       iss_vld_reg;
    logic [ADDR_W-1:0]          iss_addr_reg;
    logic [VOICE_W-1:0]         iss_voice_reg;
    logic [PAD_W-1:0]           iss_pad_reg;
    logic                       iss_last;
    logic                       iss_final;

    // Envelope stage.
    logic                       s1_vld_reg;
    logic [ADDR_W-1:0]          s1_addr_reg;
    logic [PAD_W-1:0]           s1_pad_reg;
    logic                       s1_last_reg;
    logic                       s1_final_reg;
    logic                       s1_active;
    hevm_pkg::voice_step_t      s1_step;

    // Multiply and accumulate stage.
    logic                       s2_vld_reg;
    logic                       s2_have_reg;
    logic [7:0]                 s2_amount_reg;
    logic [7:0]                 s2_gain_reg;
    logic [PAD_W-1:0]           s2_pad_reg;
    logic                       s2_last_reg;
    logic                       s2_final_reg;
    logic [15:0]                s2_product;
    logic [8:0]                 s2_total;
    logic [7:0]                 sum_next;
    logic [7:0]                 sum_reg;

    // Start slot selection.
    logic                       start_ok;
    logic [ADDR_W-1:0]          pad_base;
    logic                       slot_found;
    logic [VOICE_W-1:0]         slot_v;
    logic [4:0]                 victim_mod;
    logic [ADDR_W-1:0]          start_addr;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg == ST_TICK);
    assign done   = done_reg;

    assign intensity_pad0 = pad_int_reg[0];
    generate
        if (PAD_COUNT > 1)
        begin : g_pad1
            assign intensity_pad1 = pad_int_reg[1];
        end
        else
        begin : g_no_pad1
            assign intensity_pad1 = '0;
        end
    endgenerate

    // A start names an existing pad and a known envelope.
    assign start_ok = (pattern < 3'(hevm_pkg::NUM_PATTERNS)) &&
                      ((PAD_COUNT > 1) || !pad_sel);
    assign pad_base = pad_sel ? ADDR_W'(VOICES_PER_PAD) : '0;

    // First idle voice of the selected pad; lowest index wins.
    always_comb
    begin
        slot_found = 1'b0;
        slot_v     = '0;
        for (int v = VOICES_PER_PAD - 1; v >= 0; v--)
        begin
            if (!active_reg[pad_base + ADDR_W'(v)])
            begin
                slot_found = 1'b1;
                slot_v     = VOICE_W'(v);
            end
        end
    end

    // Victim slot reduced modulo the voice count; it never exceeds three.
    always_comb
    begin
        victim_mod = 5'(victim_slot);
        for (int i = 0; i < 3; i++)
        begin
            if (victim_mod >= 5'(VOICES_PER_PAD))
                victim_mod = victim_mod - 5'(VOICES_PER_PAD);
        end
    end

    assign start_addr = pad_base + (slot_found ? ADDR_W'(slot_v) : ADDR_W'(victim_mod));

    // Control state and handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (accept)
            begin
                if (req_type == hevm_pkg::REQ_TICK)
                    state_reg <= ST_TICK;
                else
                    done_reg <= 1'b1;
            end
            else if (s2_vld_reg && s2_final_reg)
            begin
                state_reg <= ST_IDLE;
                done_reg  <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && req_type == hevm_pkg::REQ_TICK)
            frames_reg <= frames;
    end

    // Issue counters walk every voice once per tick.
    assign iss_last  = (iss_voice_reg == VOICE_W'(VOICES_PER_PAD - 1));
    assign iss_final = iss_last && (iss_pad_reg == PAD_W'(PAD_COUNT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_vld_reg   <= 1'b0;
            iss_addr_reg  <= '0;
            iss_voice_reg <= '0;
            iss_pad_reg   <= '0;
        end
        else if (accept && req_type == hevm_pkg::REQ_TICK)
        begin
            iss_vld_reg   <= 1'b1;
            iss_addr_reg  <= '0;
            iss_voice_reg <= '0;
            iss_pad_reg   <= '0;
        end
        else if (iss_vld_reg)
        begin
            iss_addr_reg <= iss_addr_reg + 1'b1;
            if (iss_final)
                iss_vld_reg <= 1'b0;
            if (iss_last)
            begin
                iss_voice_reg <= '0;
                iss_pad_reg   <= iss_pad_reg + 1'b1;
            end
            else
            begin
                iss_voice_reg <= iss_voice_reg + 1'b1;
            end
        end
    end

    // Pipe valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= iss_vld_reg;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // Voice memory: read during the walk; written by a start or by the write-back.
    always_ff @(posedge clk)
    begin
        if (iss_vld_reg)
            rdata_reg <= voice_mem[iss_addr_reg];
        if (accept && req_type == hevm_pkg::REQ_START && start_ok)
            voice_mem[start_addr] <= '{pattern: pattern, position: '0, gain: gain};
        else if (s1_vld_reg && s1_active)
            voice_mem[s1_addr_reg] <= '{pattern:  rdata_reg.pattern,
                                        position: s1_step.position,
                                        gain:     rdata_reg.gain};
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg  <= iss_addr_reg;
        s1_pad_reg   <= iss_pad_reg;
        s1_last_reg  <= iss_last;
        s1_final_reg <= iss_final;
    end

    // Envelope step of the voice just read.
    hevm_voice_step u_step
    (
        .entry  (rdata_reg),
        .frames (frames_reg),
        .step   (s1_step)
    );

    assign s1_active = active_reg[s1_addr_reg];

    // Active flags: set by a start, cleared by stop-all or an ended envelope.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
        end
        else if (accept && req_type == hevm_pkg::REQ_STOP)
        begin
            active_reg <= '0;
        end
        else if (accept && req_type == hevm_pkg::REQ_START && start_ok)
        begin
            active_reg[start_addr] <= 1'b1;
        end
        else if (s1_vld_reg && s1_active && !s1_step.keep)
        begin
            active_reg[s1_addr_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_have_reg   <= s1_vld_reg && s1_active && s1_step.have;
        s2_amount_reg <= s1_step.amount;
        s2_gain_reg   <= rdata_reg.gain;
        s2_pad_reg    <= s1_pad_reg;
        s2_last_reg   <= s1_last_reg;
        s2_final_reg  <= s1_final_reg;
    end

    // Scaled contribution added to the running pad sum, saturating as it goes.
    assign s2_product = s2_have_reg ? (16'(s2_amount_reg) * 16'(s2_gain_reg)) : '0;
    assign s2_total   = {1'b0, sum_reg} + {1'b0, s2_product[15:8]};
    assign sum_next   = (s2_total > {1'b0, hevm_pkg::INTENSITY_MAX}) ?
                        hevm_pkg::INTENSITY_MAX : s2_total[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            for (int p = 0; p < PAD_COUNT; p++)
                pad_int_reg[p] <= '0;
        end
        else if (accept && req_type == hevm_pkg::REQ_STOP)
        begin
            sum_reg <= '0;
            for (int p = 0; p < PAD_COUNT; p++)
                pad_int_reg[p] <= '0;
        end
        else if (s2_vld_reg)
        begin
            if (s2_last_reg)
            begin
                pad_int_reg[s2_pad_reg] <= sum_next;
                sum_reg                 <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
            end
        end
    end

    // Any accepted non-tick word is answered in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req_type != hevm_pkg::REQ_TICK) |=> done)
        else $error("non-tick word not answered in the next cycle");

    // A tick walk only starts from an accepted tick word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start) && $past(req_type) == hevm_pkg::REQ_TICK)
        else $error("tick walk started without a tick word");

    // The pipe only carries voices while a tick is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_vld_reg || s2_vld_reg) |-> busy)
        else $error("pipe active outside a tick");

    // Reported intensities never exceed the saturation limit.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (intensity_pad0 <= hevm_pkg::INTENSITY_MAX) &&
                 (intensity_pad1 <= hevm_pkg::INTENSITY_MAX))
        else $error("intensity above saturation limit");

endmodule

[sv/hevm_voice_step.sv]
// Advances one voice along its envelope by the tick's frame count.
module hevm_voice_step
(
    input  hevm_pkg::voice_entry_t           entry,
    input  logic [hevm_pkg::FRAMES_W-1:0]   frames,
    output hevm_pkg::voice_step_t            step
);

    logic [hevm_pkg::POS_W:0]   target;
    logic [hevm_pkg::POS_W-1:0] len;

    assign len    = hevm_pkg::env_len(entry.pattern);
    assign target = {1'b0, entry.position} + (hevm_pkg::POS_W + 1)'(frames);

    // A zero tick leaves the voice alone; running past the end retires it.
    always_comb
    begin
        step.keep     = 1'b1;
        step.have     = 1'b0;
        step.position = entry.position;
        step.amount   = '0;
        if (frames == '0)
        begin
            step.keep = 1'b1;
        end
        else if (target > {1'b0, len})
        begin
            step.keep     = 1'b0;
            step.position = len;
        end
        else
        begin
            step.have     = 1'b1;
            step.position = target[hevm_pkg::POS_W-1:0];
            step.amount   = hevm_pkg::env_entry(entry.pattern,
                                                target[hevm_pkg::POS_W-1:0] - 6'd1);
        end
    end

endmodule
